// ----- design/pwl_pkg.sv -----
// shared widths, codes and defaults of the piecewise-linear table interpolator
`default_nettype none

package pwl_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int KEY_W          = 16;
    localparam int LVL_W          = 16;
    localparam int STATUS_W       = 2;

    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_CONVERT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_DUP   = 2'd3
    } t_status;

endpackage

`default_nettype wire

// ----- design/pwl_if.sv -----
// valid/ready channel interfaces for the request and result items
`default_nettype none

interface pwl_in_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic        [pwl_pkg::KEY_W-1:0]    raw_key;
    logic signed [pwl_pkg::LVL_W-1:0]    point_level;

    modport source (output valid, output func, output raw_key, output point_level,
                    input ready);
    modport sink   (input valid, input func, input raw_key, input point_level,
                    output ready);
endinterface

interface pwl_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [pwl_pkg::LVL_W-1:0]    level;
    logic        [pwl_pkg::STATUS_W-1:0] status;

    modport source (output valid, output level, output status, input ready);
    modport sink   (input valid, input level, input status, output ready);
endinterface

`default_nettype wire

// ----- design/pwl_ram.sv -----
// generic simple dual-port ram, one write port and one registered read port
`default_nettype none

module pwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/piecewise_linear_table_interpolator.sv -----
// piecewise-linear calibration table: sorted point store, lookup and interpolation
//
// Request channel i_in carries func, raw_key and point_level; result channel o_out
// carries level and status, one result per request. Insert (func 0) adds a point
// in key order, or reports a duplicate key or a full table. Convert (func 1) maps
// a reading to a level: clamped to the first/last point outside the key span,
// otherwise linear interpolation truncated toward zero; an empty table gives 0.
// The points live in one ram of MAX_POINTS entries with a registered read.
// A binary search does each halving as a ram read then a compare, and ends with
// a closing step when the bounds meet. An insert then shifts the upper entries
// one place up, each moved entry read and then written back. A convert between
// two points reads both points, forms two products and then their sum, and runs
// a 16-step restoring divider; a clamped convert returns the first or last level.
// One request is worked at a time; i_in.ready is high while the block waits for
// work, also while a finished result still sits in the output register.
// Reset clears the point count and drops any pending result; ram contents are
// simply ignored until written. When the receiver stalls the result is held and
// the next finished result waits in its final state until the register frees.
`default_nettype none

module piecewise_linear_table_interpolator #(
    parameter int MAX_POINTS = pwl_pkg::MAX_POINTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pwl_in_if.sink    i_in,
    pwl_out_if.source o_out
);
    import pwl_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int MEM_W  = KEY_W + LVL_W;
    localparam int PROD_W = LVL_W + KEY_W + 1;
    localparam int NUM_W  = PROD_W + 1;
    localparam int STEP_W = $clog2(LVL_W);

    typedef enum logic [4:0] {
        S_IDLE, S_SRCH, S_SRCH_W, S_POST, S_DUP, S_SHIFT, S_SHIFT_W,
        S_CV_X2, S_CV_X1, S_CV_END, S_M1, S_M2, S_SUM, S_DIV_INIT, S_DIV,
        S_DIV_END, S_OUT
    } t_state;

    t_state                    r_state;
    logic [CNT_W-1:0]          r_count;
    logic                      r_func;
    logic [KEY_W-1:0]          r_key;
    logic signed [LVL_W-1:0]   r_plevel;
    logic [CNT_W-1:0]          r_lo;
    logic [CNT_W-1:0]          r_hi;
    logic [IDX_W-1:0]          r_mid;
    logic [CNT_W-1:0]          r_j;
    logic [KEY_W-1:0]          r_x1;
    logic [KEY_W-1:0]          r_x2;
    logic signed [LVL_W-1:0]   r_y1;
    logic signed [LVL_W-1:0]   r_y2;
    logic signed [NUM_W-1:0]   r_num;
    logic signed [PROD_W-1:0]  r_prod;
    logic [KEY_W-1:0]          r_den;
    logic                      r_neg;
    logic [KEY_W-1:0]          r_rem;
    logic [LVL_W-1:0]          r_q;
    logic [STEP_W-1:0]         r_step;
    logic signed [LVL_W-1:0]   r_res_level;
    t_status                   r_res_status;
    logic                      r_o_valid;
    logic signed [LVL_W-1:0]   r_o_level;
    t_status                   r_o_status;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [MEM_W-1:0]          ram_wdata;
    logic [IDX_W-1:0]          ram_raddr;
    logic [MEM_W-1:0]          ram_rdata;
    logic [KEY_W-1:0]          rd_key;
    logic signed [LVL_W-1:0]   rd_level;

    logic [CNT_W:0]            n_sum_lohi;
    logic [IDX_W-1:0]          n_mid;
    logic signed [PROD_W-1:0]  n_prod_a;
    logic signed [PROD_W-1:0]  n_prod_b;
    logic [NUM_W-1:0]          n_mag;
    logic [KEY_W:0]            n_trial;
    logic                      n_qbit;

    assign rd_key   = ram_rdata[MEM_W-1:LVL_W];
    assign rd_level = ram_rdata[LVL_W-1:0];

    assign n_sum_lohi = {1'b0, r_lo} + {1'b0, r_hi};
    assign n_mid      = n_sum_lohi[IDX_W:1];

    assign n_prod_a = PROD_W'(r_y1) * PROD_W'($signed({1'b0, r_x2 - r_key}));
    assign n_prod_b = PROD_W'(r_y2) * PROD_W'($signed({1'b0, r_key - r_x1}));
    assign n_mag    = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);

    // one restoring step: bring down the next dividend bit, try the divisor
    assign n_trial = {r_rem, r_q[LVL_W-1]};
    assign n_qbit  = (n_trial >= {1'b0, r_den});

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_j[IDX_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_lo[IDX_W-1:0];
        case (r_state)
            S_SRCH: begin
                ram_raddr = n_mid;
            end
            S_POST: begin
                if (r_func == FUNC_CONVERT && r_lo == r_count) begin
                    ram_raddr = IDX_W'(r_count - CNT_W'(1));
                end
            end
            S_CV_X2: begin
                ram_raddr = IDX_W'(r_lo - CNT_W'(1));
            end
            S_SHIFT: begin
                if (r_j == r_lo) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_lo[IDX_W-1:0];
                    ram_wdata = {r_key, r_plevel};
                end else begin
                    ram_raddr = IDX_W'(r_j - CNT_W'(1));
                end
            end
            S_SHIFT_W: begin
                ram_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    pwl_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // in S_OUT the output register is handled by the state itself
            if (r_o_valid && o_out.ready && r_state != S_OUT) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_func      <= i_in.func;
                        r_key       <= i_in.raw_key;
                        r_plevel    <= i_in.point_level;
                        r_lo        <= '0;
                        r_hi        <= r_count;
                        r_res_level <= '0;
                        if (i_in.func == FUNC_CONVERT && r_count == '0) begin
                            r_res_status <= ST_EMPTY;
                            r_state      <= S_OUT;
                        end else begin
                            r_state <= S_SRCH;
                        end
                    end
                end
                S_SRCH: begin
                    if (r_lo == r_hi) begin
                        r_state <= S_POST;
                    end else begin
                        r_mid   <= n_mid;
                        r_state <= S_SRCH_W;
                    end
                end
                S_SRCH_W: begin
                    if (rd_key < r_key) begin
                        r_lo <= CNT_W'(r_mid) + CNT_W'(1);
                    end else begin
                        r_hi <= CNT_W'(r_mid);
                    end
                    r_state <= S_SRCH;
                end
                S_POST: begin
                    if (r_func == FUNC_INSERT) begin
                        if (r_lo != r_count) begin
                            r_state <= S_DUP;
                        end else if (r_count == CNT_W'(MAX_POINTS)) begin
                            r_res_status <= ST_FULL;
                            r_state      <= S_OUT;
                        end else begin
                            r_j     <= r_count;
                            r_state <= S_SHIFT;
                        end
                    end else if (r_lo == r_count || r_lo == '0) begin
                        r_state <= S_CV_END;
                    end else begin
                        r_state <= S_CV_X2;
                    end
                end
                S_DUP: begin
                    if (rd_key == r_key) begin
                        r_res_status <= ST_DUP;
                        r_state      <= S_OUT;
                    end else if (r_count == CNT_W'(MAX_POINTS)) begin
                        r_res_status <= ST_FULL;
                        r_state      <= S_OUT;
                    end else begin
                        r_j     <= r_count;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (r_j == r_lo) begin
                        r_count      <= r_count + CNT_W'(1);
                        r_res_status <= ST_OK;
                        r_state      <= S_OUT;
                    end else begin
                        r_state <= S_SHIFT_W;
                    end
                end
                S_SHIFT_W: begin
                    r_j     <= r_j - CNT_W'(1);
                    r_state <= S_SHIFT;
                end
                S_CV_END: begin
                    r_res_level  <= rd_level;
                    r_res_status <= ST_OK;
                    r_state      <= S_OUT;
                end
                S_CV_X2: begin
                    r_x2    <= rd_key;
                    r_y2    <= rd_level;
                    r_state <= S_CV_X1;
                end
                S_CV_X1: begin
                    r_x1    <= rd_key;
                    r_y1    <= rd_level;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_num   <= NUM_W'(n_prod_a);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_prod  <= n_prod_b;
                    r_den   <= r_x2 - r_x1;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_num   <= r_num + NUM_W'(r_prod);
                    r_state <= S_DIV_INIT;
                end
                S_DIV_INIT: begin
                    // magnitude stays below den * 2^16, so the top half starts below den
                    r_neg   <= r_num[NUM_W-1];
                    r_rem   <= n_mag[KEY_W+LVL_W-1:LVL_W];
                    r_q     <= n_mag[LVL_W-1:0];
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (n_qbit) begin
                        r_rem <= KEY_W'(n_trial - {1'b0, r_den});
                    end else begin
                        r_rem <= n_trial[KEY_W-1:0];
                    end
                    r_q    <= {r_q[LVL_W-2:0], n_qbit};
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(LVL_W - 1)) begin
                        r_state <= S_DIV_END;
                    end
                end
                S_DIV_END: begin
                    r_res_level  <= r_neg ? -$signed(r_q) : $signed(r_q);
                    r_res_status <= ST_OK;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid || o_out.ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_level  <= r_res_level;
                        r_o_status <= r_res_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_o_valid;
    assign o_out.level  = r_o_level;
    assign o_out.status = r_o_status;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count above table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CNT_W'(1) && $past(r_state) == S_SHIFT))
        else $error("point count changed other than by one insert");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH || r_state == S_SRCH_W) |-> (r_lo <= r_hi && r_hi <= r_count))
        else $error("search bounds out of order");
`endif

endmodule

`default_nettype wire
